// File: rtl/first_fit_free_list_allocator_core_defines.svh
// assertion helpers, clocked on clk with active-low rst_n in scope
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTH
// expression holds at every edge out of reset
`define FFA_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
// consequent holds in the cycle after the trigger
`define FFA_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("assertion failed");
`else
`define FFA_ASSERT(lbl, expr)
`define FFA_ASSERT_NEXT(lbl, trig, cons)
`endif

`endif

// File: rtl/ffa_pkg.sv
`timescale 1ns / 1ps
package ffa_pkg;

  localparam int MAX_REGIONS = 16;
  localparam int ADDR_W      = 32;
  localparam int IDX_W       = $clog2(MAX_REGIONS);
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // one datapath operation per cycle
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ASCAN,
    CMD_FSCAN,
    CMD_FPOS,
    CMD_FSHIFT,
    CMD_CSTART,
    CMD_CCMP,
    CMD_CREM,
    CMD_OUT
  } cmd_t;

  // datapath flags seen by the controller
  typedef struct packed {
    logic at_end;
    logic hit;
    logic touch;
    logic full;
    logic pos_found;
    logic shift_more;
    logic c_end;
    logic merge;
    logic rem_more;
    logic empty_rng;
    logic out_free;
  } dp_stat_t;

endpackage

// File: rtl/first_fit_free_list_allocator_core.sv
`timescale 1ns / 1ps
// First-fit free-list allocator with coalescing.
// Input channel (in_valid / in_stall): one request word per item, in_op 0
// allocates in_alloc_size, in_op 1 frees [in_range_start, in_range_end).
// Result channel (out_valid / out_stall): one word per request, out_status
// and out_start_address (0 unless an allocate succeeded).
// Config channel (cfg_valid / cfg_ready): writing cfg_data sets the managed
// size and restarts the list as one region [0, size); taken only when idle.
// Requests run one at a time through a list scanner with one read port.
// Sequence: an allocate scans the regions for the first fit; an empty or
// reversed free goes straight to the result; any other free scans for a
// region it touches and widens it, or else finds the insert slot and shifts
// the later entries up to make room (status full when the list has no
// room); a free that changed the list then runs coalesce compares, moving
// the later entries down on each merge. The next request is taken as soon
// as the result word is in the output register.
// A finished word waits in the output register; a new request is taken
// while it waits, and the block holds a further result until the receiver
// drops out_stall. Reset empties the list and clears the output register.
module first_fit_free_list_allocator_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic [ffa_pkg::ADDR_W-1:0] in_alloc_size,
  input  logic [ffa_pkg::ADDR_W-1:0] in_range_start,
  input  logic [ffa_pkg::ADDR_W-1:0] in_range_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [ffa_pkg::ADDR_W-1:0] out_start_address,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ffa_pkg::ADDR_W-1:0] cfg_data
);
  import ffa_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  ffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ffa_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_data          (cfg_data),
    .in_alloc_size     (in_alloc_size),
    .in_range_start    (in_range_start),
    .in_range_end      (in_range_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_start_address (out_start_address)
  );

endmodule

// File: rtl/ffa_ctrl.sv
`timescale 1ns / 1ps
module ffa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_op,
  output logic            in_stall,
  output logic            cfg_ready,
  input  ffa_pkg::dp_stat_t stat,
  output ffa_pkg::cmd_t   cmd
);
  import ffa_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_ASCAN  = 11'b00000000010,
    S_FCHK   = 11'b00000000100,
    S_FSCAN  = 11'b00000001000,
    S_FPOS   = 11'b00000010000,
    S_FSHIFT = 11'b00000100000,
    S_CSTART = 11'b00001000000,
    S_CCMP   = 11'b00010000000,
    S_CREM   = 11'b00100000000,
    S_OUT    = 11'b01000000000,
    S_SPARE  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  // sequencing
  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = in_op ? S_FCHK : S_ASCAN;
        end
      end
      S_ASCAN: begin
        cmd = CMD_ASCAN;
        if (stat.at_end || stat.hit) state_nxt = S_OUT;
      end
      S_FCHK: begin
        state_nxt = stat.empty_rng ? S_OUT : S_FSCAN;
      end
      S_FSCAN: begin
        cmd = CMD_FSCAN;
        if (stat.at_end) state_nxt = stat.full ? S_OUT : S_FPOS;
        else if (stat.touch) state_nxt = S_CSTART;
      end
      S_FPOS: begin
        cmd = CMD_FPOS;
        if (stat.pos_found) state_nxt = S_FSHIFT;
      end
      S_FSHIFT: begin
        cmd = CMD_FSHIFT;
        if (!stat.shift_more) state_nxt = S_CSTART;
      end
      S_CSTART: begin
        cmd       = CMD_CSTART;
        state_nxt = S_CCMP;
      end
      S_CCMP: begin
        cmd = CMD_CCMP;
        if (stat.c_end) state_nxt = S_OUT;
        else if (stat.merge) state_nxt = S_CREM;
      end
      S_CREM: begin
        cmd = CMD_CREM;
        if (!stat.rem_more) state_nxt = S_CCMP;
      end
      S_OUT: begin
        cmd = CMD_OUT;
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// File: rtl/ffa_dpath.sv
`timescale 1ns / 1ps
`include "first_fit_free_list_allocator_core_defines.svh"
module ffa_dpath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ffa_pkg::cmd_t              cmd,
  output ffa_pkg::dp_stat_t          stat,
  input  logic                       cfg_we,
  input  logic [ffa_pkg::ADDR_W-1:0] cfg_data,
  input  logic [ffa_pkg::ADDR_W-1:0] in_alloc_size,
  input  logic [ffa_pkg::ADDR_W-1:0] in_range_start,
  input  logic [ffa_pkg::ADDR_W-1:0] in_range_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [ffa_pkg::ADDR_W-1:0] out_start_address
);
  import ffa_pkg::*;

  // region list
  logic [ADDR_W-1:0] rs_r [MAX_REGIONS];
  logic [ADDR_W-1:0] rz_r [MAX_REGIONS];
  logic [CNT_W-1:0]  count_r, count_nxt;

  // request and working registers
  logic [ADDR_W-1:0] req_r, sa_r, ea_r;
  logic [CNT_W-1:0]  idx_r, idx_nxt, j_r, j_nxt, pos_r, pos_nxt;
  logic [ADDR_W-1:0] cur_start_r, cur_start_nxt, cur_size_r, cur_size_nxt;
  status_t           status_r, status_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [ADDR_W-1:0] out_addr_r;

  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [ADDR_W-1:0] rd_start, rd_size, rd_end, wr_start, wr_size, len;
  logic              we;
  logic [CNT_W-1:0]  j_m1, j_p1, idx_p1;
  logic [CNT_W:0]    idx_p1_w, j_p1_w;

  assign len      = ea_r - sa_r;
  assign j_m1     = j_r - 1'b1;
  assign j_p1     = j_r + 1'b1;
  assign idx_p1   = idx_r + 1'b1;
  assign idx_p1_w = {1'b0, idx_r} + 1'b1;
  assign j_p1_w   = {1'b0, j_r} + 1'b1;

  // single read port address
  always_comb begin
    unique case (cmd)
      CMD_FSHIFT: rd_addr = j_m1[IDX_W-1:0];
      CMD_CSTART: rd_addr = '0;
      CMD_CCMP:   rd_addr = idx_p1[IDX_W-1:0];
      CMD_CREM:   rd_addr = j_p1[IDX_W-1:0];
      default:    rd_addr = idx_r[IDX_W-1:0];
    endcase
  end

  assign rd_start = rs_r[rd_addr];
  assign rd_size  = rz_r[rd_addr];
  assign rd_end   = rd_start + rd_size;

  // flags
  always_comb begin
    stat            = '0;
    stat.at_end     = (idx_r >= count_r);
    stat.hit        = (rd_size > req_r);
    stat.touch      = (ea_r == rd_start) || (sa_r == rd_end);
    stat.full       = (count_r >= CNT_W'(MAX_REGIONS));
    stat.pos_found  = stat.at_end || (sa_r < rd_start);
    stat.shift_more = (j_r > pos_r);
    stat.c_end      = (idx_p1_w >= {1'b0, count_r});
    stat.merge      = ((cur_start_r + cur_size_r) == rd_start);
    stat.rem_more   = (j_p1_w < {1'b0, count_r});
    stat.empty_rng  = (ea_r <= sa_r);
    stat.out_free   = !out_valid_r || !out_stall;
  end

  // per-command update
  always_comb begin
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    j_nxt         = j_r;
    pos_nxt       = pos_r;
    cur_start_nxt = cur_start_r;
    cur_size_nxt  = cur_size_r;
    status_nxt    = status_r;
    addr_nxt      = addr_r;
    we            = 1'b0;
    wr_addr       = idx_r[IDX_W-1:0];
    wr_start      = rd_start;
    wr_size       = rd_size;
    unique case (cmd)
      CMD_LOAD: begin
        idx_nxt    = '0;
        status_nxt = ST_OK;
        addr_nxt   = '0;
      end
      CMD_ASCAN: begin
        if (stat.at_end) begin
          status_nxt = ST_NOFIT;
        end else if (stat.hit) begin
          we       = 1'b1;
          wr_start = rd_start + req_r;
          wr_size  = rd_size - req_r;
          addr_nxt = rd_start;
        end else begin
          idx_nxt = idx_p1;
        end
      end
      CMD_FSCAN: begin
        if (stat.at_end) begin
          idx_nxt = '0;
          if (stat.full) status_nxt = ST_FULL;
        end else if (stat.touch) begin
          we       = 1'b1;
          wr_start = (ea_r == rd_start) ? sa_r : rd_start;
          wr_size  = rd_size + len;
        end else begin
          idx_nxt = idx_p1;
        end
      end
      CMD_FPOS: begin
        if (stat.pos_found) begin
          pos_nxt = idx_r;
          j_nxt   = count_r;
        end else begin
          idx_nxt = idx_p1;
        end
      end
      CMD_FSHIFT: begin
        we = 1'b1;
        if (stat.shift_more) begin
          wr_addr = j_r[IDX_W-1:0];
          j_nxt   = j_m1;
        end else begin
          wr_addr   = pos_r[IDX_W-1:0];
          wr_start  = sa_r;
          wr_size   = len;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_CSTART: begin
        idx_nxt       = '0;
        cur_start_nxt = rd_start;
        cur_size_nxt  = rd_size;
      end
      CMD_CCMP: begin
        if (!stat.c_end) begin
          if (stat.merge) begin
            we           = 1'b1;
            wr_start     = cur_start_r;
            wr_size      = cur_size_r + rd_size;
            cur_size_nxt = cur_size_r + rd_size;
            j_nxt        = idx_p1;
          end else begin
            cur_start_nxt = rd_start;
            cur_size_nxt  = rd_size;
            idx_nxt       = idx_p1;
          end
        end
      end
      CMD_CREM: begin
        if (stat.rem_more) begin
          we      = 1'b1;
          wr_addr = j_r[IDX_W-1:0];
          j_nxt   = j_p1;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      default: ;
    endcase
    // list restart on a register write
    if (cfg_we) begin
      we        = 1'b1;
      wr_addr   = '0;
      wr_start  = '0;
      wr_size   = cfg_data;
      count_nxt = CNT_W'(cfg_data != '0);
    end
  end

  // list storage
  always_ff @(posedge clk) begin
    if (we) begin
      rs_r[wr_addr] <= wr_start;
      rz_r[wr_addr] <= wr_size;
    end
  end

  // request capture and working registers
  always_ff @(posedge clk) begin
    if (cmd == CMD_LOAD) begin
      req_r <= in_alloc_size;
      sa_r  <= in_range_start;
      ea_r  <= in_range_end;
    end
    idx_r       <= idx_nxt;
    j_r         <= j_nxt;
    pos_r       <= pos_nxt;
    cur_start_r <= cur_start_nxt;
    cur_size_r  <= cur_size_nxt;
    status_r    <= status_nxt;
    addr_r      <= addr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else        count_r <= count_nxt;
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd == CMD_OUT && stat.out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_OUT && stat.out_free) begin
      out_status_r <= status_r;
      out_addr_r   <= addr_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_start_address = out_addr_r;

  `FFA_ASSERT(a_count_bound, count_r <= CNT_W'(MAX_REGIONS))
  `FFA_ASSERT_NEXT(a_out_load, cmd == CMD_OUT && stat.out_free, out_valid_r)
  `FFA_ASSERT_NEXT(a_ins_grow, cmd == CMD_FSHIFT && !stat.shift_more && !cfg_we,
    count_r == $past(count_r) + 1'b1)
  `FFA_ASSERT_NEXT(a_alloc_addr, cmd == CMD_ASCAN && stat.at_end && !cfg_we,
    addr_r == '0 && status_r == ST_NOFIT)

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import ffa_pkg::*;

  localparam int CYCLE_LIMIT  = 1500000;
  localparam int DRAIN_CYCLES = 400;
  localparam int RAND_ITEMS   = 1520;

  typedef struct {
    status_t     st;
    logic [31:0] adr;
  } alloc_word_t;

  typedef struct {
    logic        op;
    logic [31:0] a;
    logic [31:0] s;
    logic [31:0] e;
    bit          typed;
    status_t     st;
    logic [31:0] adr;
  } stim_row_t;

  typedef struct {
    logic [31:0] base;
    logic [31:0] len;
  } block_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = 1'b0;
  logic [31:0] in_alloc_size = '0;
  logic [31:0] in_range_start = '0;
  logic [31:0] in_range_end = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_start_address;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  first_fit_free_list_allocator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_alloc_size(in_alloc_size), .in_range_start(in_range_start),
    .in_range_end(in_range_end),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_start_address(out_start_address),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // free list mirror
  logic [31:0] fl_start [MAX_REGIONS];
  logic [31:0] fl_size  [MAX_REGIONS];
  int          fl_count;
  logic [31:0] mem_total;

  alloc_word_t exp_q[$];
  block_t      live_q[$];
  int          err_count = 0;
  int          cycles = 0;
  bit          no_idle = 1'b0;
  int          hold_id = 0;

  function automatic void list_init(logic [31:0] total);
    mem_total = total;
    fl_count = (total != 0) ? 1 : 0;
    fl_start[0] = '0;
    fl_size[0] = total;
  endfunction

  function automatic void drop_entry(int idx);
    for (int i = idx; i + 1 < fl_count; i++) begin
      fl_start[i] = fl_start[i+1];
      fl_size[i] = fl_size[i+1];
    end
    if (fl_count > 0) fl_count--;
  endfunction

  function automatic void join_adjacent();
    int i;
    logic [31:0] tail;
    i = 0;
    while (i + 1 < fl_count) begin
      tail = fl_start[i] + fl_size[i];
      if (tail == fl_start[i+1]) begin
        fl_size[i] = fl_size[i] + fl_size[i+1];
        drop_entry(i + 1);
      end else begin
        i++;
      end
    end
  endfunction

  function automatic status_t release_range(logic [31:0] sa, logic [31:0] ea);
    logic [31:0] len, tail;
    int pos;
    if (ea <= sa) return ST_OK;
    len = ea - sa;
    for (int i = 0; i < fl_count; i++) begin
      tail = fl_start[i] + fl_size[i];
      if (ea == fl_start[i] || sa == tail) begin
        if (ea == fl_start[i]) fl_start[i] = sa;
        fl_size[i] = fl_size[i] + len;
        join_adjacent();
        return ST_OK;
      end
    end
    if (fl_count >= MAX_REGIONS) return ST_FULL;
    pos = fl_count;
    for (int i = 0; i < fl_count; i++) begin
      if (sa < fl_start[i]) begin
        pos = i;
        break;
      end
    end
    for (int i = fl_count; i > pos; i--) begin
      fl_start[i] = fl_start[i-1];
      fl_size[i] = fl_size[i-1];
    end
    fl_start[pos] = sa;
    fl_size[pos] = len;
    fl_count++;
    join_adjacent();
    return ST_OK;
  endfunction

  // expected word for one request, updates the mirror
  function automatic alloc_word_t predict_word(logic op, logic [31:0] a, logic [31:0] s,
                                               logic [31:0] e);
    alloc_word_t w;
    block_t b;
    w.st = ST_NOFIT;
    w.adr = '0;
    if (op == 1'b0) begin
      for (int i = 0; i < fl_count; i++) begin
        if (fl_size[i] > a) begin
          w.st = ST_OK;
          w.adr = fl_start[i];
          fl_size[i] = fl_size[i] - a;
          fl_start[i] = fl_start[i] + a;
          break;
        end
      end
      if (w.st == ST_OK && a != 0) begin
        b.base = w.adr;
        b.len = a;
        live_q.push_back(b);
      end
    end else begin
      w.st = release_range(s, e);
    end
    return w;
  endfunction

  // one request word through the input handshake
  task automatic send_word(logic op, logic [31:0] a, logic [31:0] s, logic [31:0] e,
                           bit typed, status_t tst, logic [31:0] tadr);
    alloc_word_t w;
    if (!no_idle && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_alloc_size <= a;
    in_range_start <= s;
    in_range_end <= e;
    do @(posedge clk); while (in_stall);
    w = predict_word(op, a, s, e);
    if (typed) begin
      w.st = tst;
      w.adr = tadr;
    end
    exp_q.push_back(w);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_total(logic [31:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_data <= $urandom();
    list_init(v);
    live_q.delete();
  endtask

  // one random request, mostly well formed
  task automatic random_word();
    int k;
    logic [31:0] a, s, e, lim;
    block_t b;
    k = $urandom_range(99);
    lim = (mem_total > 64) ? mem_total >> 3 : 64;
    if (k < 10) begin
      send_word(1'($urandom_range(1)), $urandom(), $urandom(), $urandom(), 0, ST_OK, '0);
    end else if (k < 50) begin
      a = (k < 14) ? $urandom() : $urandom_range(lim, 1);
      send_word(1'b0, a, $urandom(), $urandom(), 0, ST_OK, '0);
    end else if (k < 88 && live_q.size() != 0) begin
      k = $urandom_range(live_q.size() - 1);
      b = live_q[k];
      live_q.delete(k);
      s = b.base;
      e = b.base + b.len;
      // sometimes only part of the block
      if ($urandom_range(3) == 0 && b.len > 2) e = s + $urandom_range(b.len - 1, 1);
      send_word(1'b1, $urandom(), s, e, 0, ST_OK, '0);
    end else begin
      // scattered small range, builds up fragments
      s = $urandom_range(lim * 4);
      e = s + $urandom_range(16, 1);
      send_word(1'b1, $urandom(), s, e, 0, ST_OK, '0);
    end
  endtask

  stim_row_t rows[$];

  function automatic void add_row(logic op, logic [31:0] a, logic [31:0] s, logic [31:0] e,
                                  bit typed, status_t st, logic [31:0] adr);
    stim_row_t r;
    r.op = op; r.a = a; r.s = s; r.e = e;
    r.typed = typed; r.st = st; r.adr = adr;
    rows.push_back(r);
  endfunction

  // result checker
  always @(posedge clk) begin
    alloc_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_q.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected word: status %0d addr %h",
                                      out_status, out_start_address);
      end else begin
        w = exp_q.pop_front();
        if (out_status !== w.st || out_start_address !== w.adr) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: exp status %0d addr %h, got status %0d addr %h",
                     w.st, w.adr, out_status, out_start_address);
        end
      end
    end
  end

  // receiver stall, long hold-offs on request
  int hold_left = 0;
  int hold_seen = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_id) begin
      hold_seen <= hold_id;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else begin
      out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 35);
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    list_init('0);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset state: empty list
    send_word(1'b0, 32'd5, '0, '0, 1, ST_NOFIT, '0);
    send_word(1'b1, '0, 32'd10, 32'd5, 1, ST_OK, '0);
    send_word(1'b1, '0, 32'd100, 32'd200, 1, ST_OK, '0);
    send_word(1'b0, 32'd50, '0, '0, 1, ST_OK, 32'd100);

    write_total(32'd1000);
    add_row(1'b0, 32'd0, '0, '0, 1, ST_OK, 32'd0);
    add_row(1'b0, 32'd1, '0, '0, 1, ST_OK, 32'd0);
    add_row(1'b0, 32'd999, '0, '0, 1, ST_NOFIT, '0);
    add_row(1'b0, 32'hFFFF_FFFF, '0, '0, 1, ST_NOFIT, '0);
    add_row(1'b0, 32'd99, '0, '0, 0, ST_OK, '0);
    add_row(1'b0, 32'd100, '0, '0, 0, ST_OK, '0);
    add_row(1'b1, '0, 32'd0, 32'd100, 0, ST_OK, '0);
    add_row(1'b1, '0, 32'd100, 32'd200, 0, ST_OK, '0);
    add_row(1'b1, '0, 32'd5000, 32'd6000, 0, ST_OK, '0);
    add_row(1'b1, '0, 32'd7000, 32'd7000, 1, ST_OK, '0);
    add_row(1'b1, '0, 32'hFFFF_FFFF, 32'd0, 1, ST_OK, '0);
    add_row(1'b1, '0, 32'hFFFF_FF00, 32'hFFFF_FFFF, 0, ST_OK, '0);
    add_row(1'b1, '0, 32'd500, 32'd600, 0, ST_OK, '0);
    add_row(1'b0, 32'd4000, '0, '0, 0, ST_OK, '0);
    for (int i = 0; i < 10; i++) add_row(1'b1, '0, 32'd10000 + 20 * i, 32'd10005 + 20 * i,
                                         0, ST_OK, '0);
    foreach (rows[i]) send_word(rows[i].op, rows[i].a, rows[i].s, rows[i].e,
                                rows[i].typed, rows[i].st, rows[i].adr);

    // random phases over several sizes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_total(32'hFFFF_FFFF);
        1: write_total(32'd0);
        2: write_total(32'd1);
        7: write_total(32'd2048);
        default: write_total($urandom_range(5000, 2));
      endcase
      for (int n = 0; n < RAND_ITEMS / 8; n++) begin
        no_idle = (ph == 3 && n < 120);
        if (ph == 4 && n == 40) hold_id++;
        if (ph == 5 && n == 60) begin
          in_valid <= 1'b0;
          while (exp_q.size() != 0) @(posedge clk);
        end
        random_word();
      end
    end
    no_idle = 1'b0;

    in_valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ffa_pkg.sv
rtl/ffa_ctrl.sv
rtl/ffa_dpath.sv
rtl/first_fit_free_list_allocator_core.sv
tb/tb_top.sv
